>>> src/swm_pkg.sv
// Package for the sliding-window median unit.
// Holds default parameters and widths; no dependencies.
`default_nettype none
package swm_pkg;
    localparam int unsigned DefWindow     = 31;
    localparam int unsigned DefSampleBits = 16;
endpackage
`default_nettype wire

>>> src/sliding_window_median_unit.sv
// Sliding-window median: two heaps in one memory, one shared compare/swap unit.
// A load beat writes the sample; the beat that fills the window runs an
// insertion sort of up to WINDOW*(WINDOW-1)/2 shift steps, then copies each
// entry to split the heaps; an update writes the new sample, sifts it up, then
// down, level by level, and then checks the two roots.
// One beat at a time. Reset (synchronous, active low) clears fill count, oldest slot, control.
`default_nettype none
module sliding_window_median_unit
    import swm_pkg::*;
#(
    parameter int unsigned WINDOW      = DefWindow,
    parameter int unsigned SAMPLE_BITS = DefSampleBits
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_mode,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic signed [SAMPLE_BITS-1:0]      o_median,
    output logic                               o_window_full
);
    localparam int unsigned LO = WINDOW / 2 + 1;
    localparam int unsigned HI = WINDOW - LO;
    localparam int unsigned PW = $clog2(WINDOW);
    localparam int unsigned CW = $clog2(WINDOW + 1);

    typedef logic [PW-1:0] t_pos;
    typedef struct packed {
        t_pos                    slot;
        logic [SAMPLE_BITS-1:0]  val;
    } t_ent;

    typedef enum logic [4:0] {
        S_IDLE, S_PUT, S_SORT_RD, S_SORT_LD, S_SORT_CMP, S_SORT_WR, S_BLD_RD, S_BLD_WR,
        S_UPD_RD, S_UPD_WR,
        S_SIFT_WT, S_SIFT_RP, S_SIFT_WC, S_SIFT_RC, S_SIFT_RC2, S_SIFT_DEC,
        S_SWAP_A, S_SWAP_B,
        S_ROOT_RA, S_ROOT_RB, S_ROOT_DEC,
        S_OUT_RD, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        PH_MAXUP, PH_MAXDN, PH_MINUP, PH_MINDN, PH_FIXDN, PH_FIXMIN, PH_ROOTSW
    } t_phase;

    // heap memory (one write port, one registered read port)
    t_ent mem [WINDOW];
    t_pos loc [WINDOW];
    t_ent r_rd;
    t_pos r_rda, r_loc_rd;
    logic        w_we;
    t_pos        w_wa;
    t_ent        w_wd;
    t_ent        sort_mem [WINDOW];
    logic        s_we;
    t_pos        s_wa;
    t_ent        s_wd;
    t_ent        r_srd;
    t_pos        r_srda;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
            loc[w_wd.slot] <= w_wa;
        end
        r_rd     <= mem[r_rda];
        r_loc_rd <= loc[r_rda];
        if (s_we) begin
            sort_mem[s_wa] <= s_wd;
        end
        r_srd <= sort_mem[r_srda];
    end

    t_state r_state;
    t_phase r_ph;
    logic [CW-1:0] r_fill;
    t_pos   r_oldest;
    t_pos   r_i, r_k, r_best;
    t_ent   r_a, r_b, r_e;
    logic [SAMPLE_BITS-1:0] r_smp;
    logic   r_full;
    logic signed [SAMPLE_BITS-1:0] r_med;

    function automatic logic gt(input t_ent x, input t_ent y);
        return $signed(x.val) > $signed(y.val);
    endfunction

    // heap-relative index helpers: base and bound for the active heap
    logic  w_min;
    t_pos  w_base;
    t_pos  w_rel;
    logic [PW:0] w_lc, w_rc;
    t_pos  w_bound;
    always_comb begin
        w_min   = (r_ph == PH_MINUP) || (r_ph == PH_MINDN) || (r_ph == PH_FIXMIN);
        w_base  = w_min ? t_pos'(LO) : '0;
        w_bound = w_min ? t_pos'(HI) : t_pos'(LO);
        w_rel   = r_i - w_base;
        w_lc    = {w_rel, 1'b1};
        w_rc    = w_lc + 1'b1;
    end

    // better(x,y): x belongs above y in the active heap
    function automatic logic better(input logic mn, input t_ent x, input t_ent y);
        return mn ? gt(y, x) : gt(x, y);
    endfunction

    // sort step: element k-1 is larger than the held one, so it moves up
    logic w_shift;
    assign w_shift = (r_k != '0) && gt(r_srd, r_e);

    always_comb begin
        w_we = 1'b0; w_wa = r_i; w_wd = r_a;
        s_we = 1'b0; s_wa = r_k; s_wd = r_e;
        unique case (r_state)
            S_PUT:     begin w_we = 1'b1; w_wa = t_pos'(r_fill); w_wd = r_e; end
            S_BLD_WR:  begin w_we = 1'b1; w_wa = r_i; w_wd = r_srd; end
            S_UPD_WR:  begin w_we = 1'b1; w_wa = r_loc_rd; w_wd = r_e; end
            S_SWAP_A:  begin w_we = 1'b1; w_wa = r_i; w_wd = r_b; end
            S_SWAP_B:  begin w_we = 1'b1; w_wa = r_best; w_wd = r_a; end
            S_SORT_CMP: begin s_we = 1'b1; s_wa = r_k; s_wd = w_shift ? r_srd : r_e; end
            default: ;
        endcase
        if (r_state == S_PUT) begin
            s_we = 1'b1; s_wa = t_pos'(r_fill); s_wd = r_e;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_oldest <= '0;
            o_valid  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_smp <= i_sample;
                        if (i_mode && r_fill >= CW'(WINDOW)) begin
                            r_rda   <= r_oldest;
                            r_state <= S_UPD_RD;
                        end else begin
                            if (r_fill >= CW'(WINDOW)) begin
                                r_fill <= '0;
                                r_e    <= '{slot: '0, val: i_sample};
                            end else begin
                                r_e <= '{slot: t_pos'(r_fill), val: i_sample};
                            end
                            r_state <= S_PUT;
                        end
                    end
                end
                S_PUT: begin
                    r_fill <= r_fill + 1'b1;
                    if (r_fill == CW'(WINDOW - 1)) begin
                        r_oldest <= '0;
                        r_i      <= t_pos'(1);
                        r_srda   <= t_pos'(1);
                        r_state  <= S_SORT_RD;
                    end else begin
                        r_full  <= 1'b0;
                        r_med   <= '0;
                        o_valid <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                // insertion sort in sort_mem: hold element i, shift larger ones up
                S_SORT_RD: begin
                    r_k     <= r_i;
                    r_srda  <= r_i - 1'b1;
                    r_state <= S_SORT_LD;
                end
                S_SORT_LD: begin
                    r_e     <= r_srd;
                    r_state <= S_SORT_CMP;
                end
                S_SORT_WR: r_state <= S_SORT_CMP;
                S_SORT_CMP: begin
                    if (w_shift) begin
                        r_k <= r_k - 1'b1;
                        if (r_k > t_pos'(1)) begin
                            r_srda <= r_k - t_pos'(2);
                        end
                        r_state <= S_SORT_WR;
                    end else if (r_i == t_pos'(WINDOW - 1)) begin
                        r_i     <= '0;
                        r_srda  <= t_pos'(LO - 1);
                        r_state <= S_BLD_RD;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_srda  <= r_i + 1'b1;
                        r_state <= S_SORT_RD;
                    end
                end
                // lower half reversed into the max-heap, upper half as is
                S_BLD_RD: r_state <= S_BLD_WR;
                S_BLD_WR: begin
                    if (r_i == t_pos'(WINDOW - 1)) begin
                        r_rda   <= '0;
                        r_state <= S_OUT_RD;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_srda  <= (r_i + 1'b1 < t_pos'(LO)) ? t_pos'(LO - 2) - r_i
                                                              : r_i + 1'b1;
                        r_state <= S_BLD_RD;
                    end
                end
                S_UPD_RD: begin
                    r_e     <= '{slot: r_oldest, val: r_smp};
                    r_state <= S_UPD_WR;
                end
                S_UPD_WR: begin
                    r_oldest <= (r_oldest == t_pos'(WINDOW - 1)) ? '0 : r_oldest + 1'b1;
                    r_ph     <= (r_loc_rd < t_pos'(LO)) ? PH_MAXUP : PH_MINUP;
                    r_i      <= r_loc_rd;
                    r_k      <= r_loc_rd;
                    r_rda    <= r_loc_rd;
                    r_state  <= S_SIFT_WT;
                end
                S_SIFT_WT: r_state <= S_SIFT_RP;
                // read node, then parent (up) or children (down)
                S_SIFT_RP: begin
                    r_a <= r_rd;
                    if (r_ph == PH_MAXUP || r_ph == PH_MINUP) begin
                        if (w_rel == '0) begin
                            r_ph    <= (r_ph == PH_MAXUP) ? PH_MAXDN : PH_MINDN;
                            r_i     <= r_k;
                            r_rda   <= r_k;
                            r_state <= S_SIFT_WT;
                        end else begin
                            r_best  <= w_base + t_pos'((w_rel - 1'b1) >> 1);
                            r_rda   <= w_base + t_pos'((w_rel - 1'b1) >> 1);
                            r_state <= S_SIFT_WC;
                        end
                    end else begin
                        r_best <= r_i;
                        r_b    <= r_rd;
                        if (w_lc < {1'b0, w_bound}) begin
                            r_rda   <= w_base + t_pos'(w_lc);
                            r_state <= S_SIFT_WC;
                        end else begin
                            r_state <= S_SIFT_DEC;
                        end
                    end
                end
                // issue the right child read while the left child is in flight
                S_SIFT_WC: begin
                    if (r_ph != PH_MAXUP && r_ph != PH_MINUP && w_rc < {1'b0, w_bound}) begin
                        r_rda <= w_base + t_pos'(w_rc);
                    end
                    r_state <= S_SIFT_RC;
                end
                S_SIFT_RC: begin
                    if (r_ph == PH_MAXUP || r_ph == PH_MINUP) begin
                        r_b <= r_rd;
                        r_state <= S_SIFT_DEC;
                    end else begin
                        if (better(w_min, r_rd, r_b)) begin
                            r_b <= r_rd; r_best <= w_base + t_pos'(w_lc);
                        end
                        if (w_rc < {1'b0, w_bound}) begin
                            r_state <= S_SIFT_RC2;
                        end else begin
                            r_state <= S_SIFT_DEC;
                        end
                    end
                end
                S_SIFT_RC2: begin
                    if (better(w_min, r_rd, r_b)) begin
                        r_b <= r_rd; r_best <= w_base + t_pos'(w_rc);
                    end
                    r_state <= S_SIFT_DEC;
                end
                S_SIFT_DEC: begin
                    if (r_ph == PH_MAXUP || r_ph == PH_MINUP) begin
                        if (better(w_min, r_a, r_b)) begin
                            r_state <= S_SWAP_A;
                        end else begin
                            r_ph    <= (r_ph == PH_MAXUP) ? PH_MAXDN : PH_MINDN;
                            r_i     <= r_k;
                            r_rda   <= r_k;
                            r_state <= S_SIFT_WT;
                        end
                    end else if (r_best != r_i) begin
                        r_state <= S_SWAP_A;
                    end else begin
                        unique case (r_ph)
                            PH_FIXDN: begin
                                r_ph <= PH_FIXMIN; r_i <= t_pos'(LO);
                                r_rda <= t_pos'(LO); r_state <= S_SIFT_WT;
                            end
                            PH_MAXDN, PH_MINDN: begin
                                r_rda <= '0; r_state <= S_ROOT_RA;
                            end
                            default: begin
                                r_rda <= '0; r_state <= S_OUT_RD;
                            end
                        endcase
                    end
                end
                S_SWAP_A: r_state <= S_SWAP_B;
                S_SWAP_B: begin
                    if (r_ph == PH_ROOTSW) begin
                        // roots crossed: sift the max-heap down from its root
                        r_ph  <= PH_FIXDN;
                        r_i   <= '0;
                        r_k   <= '0;
                        r_rda <= '0;
                    end else begin
                        r_i   <= r_best;
                        r_k   <= r_best;
                        r_rda <= r_best;
                    end
                    r_state <= S_SIFT_WT;
                end
                S_ROOT_RA: begin
                    r_rda   <= t_pos'(LO);
                    r_state <= S_ROOT_RB;
                end
                S_ROOT_RB: begin
                    r_a     <= r_rd;
                    r_state <= S_ROOT_DEC;
                end
                S_ROOT_DEC: begin
                    if (HI > 0 && gt(r_a, r_rd)) begin
                        r_b     <= r_rd;
                        r_i     <= '0;
                        r_best  <= t_pos'(LO);
                        r_ph    <= PH_ROOTSW;
                        r_state <= S_SWAP_A;
                    end else begin
                        r_rda   <= '0;
                        r_state <= S_OUT_RD;
                    end
                end
                S_OUT_RD: r_state <= S_OUT;
                S_OUT: begin
                    if (!o_valid) begin
                        o_valid <= 1'b1;
                        r_full  <= 1'b1;
                        r_med   <= $signed(r_rd.val);
                    end else if (!i_stall) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_median      = r_med;
    assign o_window_full = r_full;
endmodule
`default_nettype wire
